FILE: rtl/core/point_segment_shortest_vector_top_macros.svh
// Assertion helpers shared by the RTL files.
// Every macro samples on clock and is disabled while reset is high.
`ifndef POINT_SEGMENT_SHORTEST_VECTOR_TOP_MACROS_SVH
`define POINT_SEGMENT_SHORTEST_VECTOR_TOP_MACROS_SVH

// When ante holds, cons must hold in the same cycle.
`define PSSV_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define PSSV_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pssv_pkg.sv
package pssv_pkg;

   // default geometry
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // distance format: unsigned, DIST_FRAC fraction bits, DIST_BITS total
   localparam int DIST_FRAC = 8;
   localparam int DIST_BITS = 25;

   // which part of the segment the shortest vector starts from
   typedef enum logic [1:0] {
      REGION_BEFORE   = 2'd0,
      REGION_AFTER    = 2'd1,
      REGION_INTERIOR = 2'd2
   } region_type;

endpackage

FILE: rtl/core/point_segment_shortest_vector_top.sv
// Shortest vector from a query point to a 2-D segment. Each request word
// carries the point and the segment ends; each response word carries the
// vector origin (segment start, or end when the point lies past it), the
// tip (the point, or the start plus the point's offset normal to the
// segment, saturated), the region code and the length in unsigned Q17.8.
// The pipeline takes one word every cycle while it is not stalled. Its
// depth is set by the bit-per-stage divider that normalizes the direction
// (2*FRAC_BITS+1 stages) and the two bit-per-stage square root units.
// The two-word output queue registers each result before it is offered
// and lets the pipeline keep moving while a result waits; the whole
// pipeline stalls only when that queue is full and the response side is
// not ready. No request word is taken while reset is high. No state is
// kept between words.
`include "point_segment_shortest_vector_top_macros.svh"

module point_segment_shortest_vector_top
   import pssv_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int IN_TW     = ((6 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_FW    = 4 * COORD_BITS + DIST_BITS,
   localparam int OUT_TW    = ((OUT_FW + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
   input  logic [IN_TW-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // vec_from_x, vec_from_y, vec_to_x, vec_to_y, distance
   output logic [OUT_TW-1:0] rsp_tdata,
   // region
   output logic [1:0]        rsp_tuser
);

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int DW   = C + 1;
   localparam int L2W  = 2 * C + 1;
   localparam int QW   = 2 * F + 1;
   localparam int UR   = F + 1;
   localparam int UW   = F + 2;
   localparam int PRD  = DW + UW;
   localparam int DOTW = PRD + 1;
   localparam int PRP  = DOTW + UW;
   localparam int NUMW = PRP + 1;
   localparam int TW   = C + 3;
   localparam int SQW  = 2 * C + 3;
   localparam int DSW  = SQW + 2 * DIST_FRAC;
   localparam int DK   = (DSW + 1) / 2;
   localparam int DCW  = (DK > DIST_BITS) ? DK : DIST_BITS;
   localparam int CPW  = 6 * C + 3;
   localparam int RPW  = 4 * C + 2;
   localparam int FQW  = OUT_FW + 2;

   // coordinate slots, in request word order
   localparam int IDX_PX = 0;
   localparam int IDX_PY = 1;
   localparam int IDX_SX = 2;
   localparam int IDX_SY = 3;
   localparam int IDX_EX = 4;
   localparam int IDX_EY = 5;

   localparam logic signed [TW-1:0]  TIP_HI   = {{(TW-C+1){1'b0}}, {(C-1){1'b1}}};
   localparam logic signed [TW-1:0]  TIP_LO   = {{(TW-C+1){1'b1}}, {(C-1){1'b0}}};
   localparam logic [NUMW-1:0]       TRUNC_B  = {{(NUMW-2*F){1'b0}}, {(2*F){1'b1}}};
   localparam logic [DCW-1:0]        DIST_MAX = DCW'({DIST_BITS{1'b1}});

   logic en;

   // ---------------- stage a: capture, direction -----------------------
   logic                  a_valid_ff;
   logic [5:0][C-1:0]     a_crd_ff;
   logic signed [DW-1:0]  a_vx_ff, a_vy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
      if (en) begin
         a_crd_ff <= req_tdata[6*C-1:0];
         a_vx_ff  <= DW'($signed(req_tdata[IDX_EX*C +: C]))
                   - DW'($signed(req_tdata[IDX_SX*C +: C]));
         a_vy_ff  <= DW'($signed(req_tdata[IDX_EY*C +: C]))
                   - DW'($signed(req_tdata[IDX_SY*C +: C]));
      end
   end

   // ---------------- stage b: squared components ----------------------
   logic                  b_valid_ff;
   logic [5:0][C-1:0]     b_crd_ff;
   logic [L2W-1:0]        b_sqx_ff, b_sqy_ff;
   logic                  b_lz_ff;
   logic [1:0]            b_sgn_ff;
   logic signed [2*DW-1:0] b_sqx_in, b_sqy_in;

   assign b_sqx_in = (2*DW)'(a_vx_ff) * (2*DW)'(a_vx_ff);
   assign b_sqy_in = (2*DW)'(a_vy_ff) * (2*DW)'(a_vy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         b_crd_ff <= a_crd_ff;
         b_sqx_ff <= b_sqx_in[L2W-1:0];
         b_sqy_ff <= b_sqy_in[L2W-1:0];
         b_lz_ff  <= (a_vx_ff == '0) && (a_vy_ff == '0);
         b_sgn_ff <= {a_vy_ff[DW-1], a_vx_ff[DW-1]};
      end
   end

   // ---------------- stage c: squared length --------------------------
   logic                  c_valid_ff;
   logic [5:0][C-1:0]     c_crd_ff;
   logic [L2W-1:0]        c_sqx_ff, c_sqy_ff, c_l2_ff;
   logic                  c_lz_ff;
   logic [1:0]            c_sgn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
      if (en) begin
         c_crd_ff <= b_crd_ff;
         c_sqx_ff <= b_sqx_ff;
         c_sqy_ff <= b_sqy_ff;
         c_l2_ff  <= b_sqx_ff + b_sqy_ff;
         c_lz_ff  <= b_lz_ff;
         c_sgn_ff <= b_sgn_ff;
      end
   end

   // ---------------- unit direction: c^2 * 4^F / l2, then root --------
   logic                  dv_valid;
   logic [1:0][QW-1:0]    dv_quot;
   logic [CPW-1:0]        dv_pay;
   logic                  sq_valid;
   logic [1:0][UR-1:0]    sq_root;
   logic [CPW-1:0]        sq_pay;

   pssv_div_pipe #(
      .NW (L2W),
      .QW (QW),
      .PW (CPW)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (c_valid_ff),
      .in_numer    ({c_sqy_ff, c_sqx_ff}),
      .in_denom    (c_l2_ff),
      .in_payload  ({c_crd_ff, c_lz_ff, c_sgn_ff}),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_payload (dv_pay)
   );

   pssv_sqrt_pipe #(
      .W     (QW),
      .LANES (2),
      .PW    (CPW)
   ) u_unit_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (dv_valid),
      .in_data     (dv_quot),
      .in_payload  (dv_pay),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_payload (sq_pay)
   );

   // ---------------- stage u: signed unit vector, offsets -------------
   logic [5:0][C-1:0]     sq_crd;
   logic                  sq_lz;
   logic [1:0]            sq_sgn;

   assign sq_crd = sq_pay[CPW-1:3];
   assign sq_lz  = sq_pay[2];
   assign sq_sgn = sq_pay[1:0];

   logic                  u_valid_ff;
   logic [5:0][C-1:0]     u_crd_ff;
   logic signed [UW-1:0]  u_ux_ff, u_uy_ff, u_ux_in, u_uy_in;
   logic signed [DW-1:0]  u_wx_ff, u_wy_ff, u_zx_ff, u_zy_ff;

   always_comb begin
      u_ux_in = sq_sgn[0] ? -$signed(UW'(sq_root[0])) : $signed(UW'(sq_root[0]));
      u_uy_in = sq_sgn[1] ? -$signed(UW'(sq_root[1])) : $signed(UW'(sq_root[1]));
      if (sq_lz) begin
         u_ux_in = '0;
         u_uy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
      end else if (en) begin
         u_valid_ff <= sq_valid;
      end
      if (en) begin
         u_crd_ff <= sq_crd;
         u_ux_ff  <= u_ux_in;
         u_uy_ff  <= u_uy_in;
         u_wx_ff  <= DW'($signed(sq_crd[IDX_PX])) - DW'($signed(sq_crd[IDX_SX]));
         u_wy_ff  <= DW'($signed(sq_crd[IDX_PY])) - DW'($signed(sq_crd[IDX_SY]));
         u_zx_ff  <= DW'($signed(sq_crd[IDX_PX])) - DW'($signed(sq_crd[IDX_EX]));
         u_zy_ff  <= DW'($signed(sq_crd[IDX_PY])) - DW'($signed(sq_crd[IDX_EY]));
      end
   end

   // ---------------- stage m: dot and cross products ------------------
   logic                  m_valid_ff;
   logic [5:0][C-1:0]     m_crd_ff;
   logic signed [UW-1:0]  m_ux_ff, m_uy_ff;
   logic signed [PRD-1:0] m_wxux_ff, m_wyuy_ff, m_zxux_ff, m_zyuy_ff;
   logic signed [PRD-1:0] m_wxuy_ff, m_wyux_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= u_valid_ff;
      end
      if (en) begin
         m_crd_ff  <= u_crd_ff;
         m_ux_ff   <= u_ux_ff;
         m_uy_ff   <= u_uy_ff;
         m_wxux_ff <= PRD'(u_wx_ff) * PRD'(u_ux_ff);
         m_wyuy_ff <= PRD'(u_wy_ff) * PRD'(u_uy_ff);
         m_zxux_ff <= PRD'(u_zx_ff) * PRD'(u_ux_ff);
         m_zyuy_ff <= PRD'(u_zy_ff) * PRD'(u_uy_ff);
         m_wxuy_ff <= PRD'(u_wx_ff) * PRD'(u_uy_ff);
         m_wyux_ff <= PRD'(u_wy_ff) * PRD'(u_ux_ff);
      end
   end

   // ---------------- stage r: region decision, normal distance --------
   logic                   r_valid_ff;
   logic [5:0][C-1:0]      r_crd_ff;
   logic signed [UW-1:0]   r_ux_ff, r_uy_ff;
   logic signed [DOTW-1:0] r_d_ff, r_dot_s, r_dot_e;
   region_type             r_region_ff, r_region_in;

   assign r_dot_s = DOTW'(m_wxux_ff) + DOTW'(m_wyuy_ff);
   assign r_dot_e = DOTW'(m_zxux_ff) + DOTW'(m_zyuy_ff);

   always_comb begin
      if (r_dot_s[DOTW-1]) begin
         r_region_in = REGION_BEFORE;
      end else if (!r_dot_e[DOTW-1] && (r_dot_e != '0)) begin
         r_region_in = REGION_AFTER;
      end else begin
         r_region_in = REGION_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (en) begin
         r_valid_ff <= m_valid_ff;
      end
      if (en) begin
         r_crd_ff    <= m_crd_ff;
         r_ux_ff     <= m_ux_ff;
         r_uy_ff     <= m_uy_ff;
         r_d_ff      <= DOTW'(m_wxuy_ff) - DOTW'(m_wyux_ff);
         r_region_ff <= r_region_in;
      end
   end

   // ---------------- stage n: foot offset products --------------------
   logic                  n_valid_ff;
   logic [5:0][C-1:0]     n_crd_ff;
   logic signed [PRP-1:0] n_pdy_ff, n_pdx_ff;
   region_type            n_region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (en) begin
         n_valid_ff <= r_valid_ff;
      end
      if (en) begin
         n_crd_ff    <= r_crd_ff;
         n_region_ff <= r_region_ff;
         n_pdy_ff    <= PRP'(r_d_ff) * PRP'(r_uy_ff);
         n_pdx_ff    <= PRP'(r_d_ff) * PRP'(r_ux_ff);
      end
   end

   // ---------------- stage t: foot in Q.2F ----------------------------
   logic                   t_valid_ff;
   logic [5:0][C-1:0]      t_crd_ff;
   logic signed [NUMW-1:0] t_numx_ff, t_numy_ff;
   region_type             t_region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff <= n_valid_ff;
      end
      if (en) begin
         t_crd_ff    <= n_crd_ff;
         t_region_ff <= n_region_ff;
         t_numx_ff   <= (NUMW'($signed(n_crd_ff[IDX_SX])) <<< (2*F)) + NUMW'(n_pdy_ff);
         t_numy_ff   <= (NUMW'($signed(n_crd_ff[IDX_SY])) <<< (2*F)) - NUMW'(n_pdx_ff);
      end
   end

   // ---------------- stage f: truncate toward zero, pick ends ---------
   logic                   f_valid_ff;
   logic [1:0][C-1:0]      f_from_ff, f_from_in;
   logic signed [TW-1:0]   f_tipx_ff, f_tipy_ff, f_tipx_in, f_tipy_in;
   region_type             f_region_ff;
   logic [NUMW-1:0]        f_sumx, f_sumy;

   assign f_sumx = t_numx_ff + (t_numx_ff[NUMW-1] ? TRUNC_B : '0);
   assign f_sumy = t_numy_ff + (t_numy_ff[NUMW-1] ? TRUNC_B : '0);

   always_comb begin
      case (t_region_ff)
         REGION_INTERIOR: begin
            f_from_in = {t_crd_ff[IDX_SY], t_crd_ff[IDX_SX]};
            f_tipx_in = f_sumx[2*F +: TW];
            f_tipy_in = f_sumy[2*F +: TW];
         end
         REGION_AFTER: begin
            f_from_in = {t_crd_ff[IDX_EY], t_crd_ff[IDX_EX]};
            f_tipx_in = TW'($signed(t_crd_ff[IDX_PX]));
            f_tipy_in = TW'($signed(t_crd_ff[IDX_PY]));
         end
         default: begin
            f_from_in = {t_crd_ff[IDX_SY], t_crd_ff[IDX_SX]};
            f_tipx_in = TW'($signed(t_crd_ff[IDX_PX]));
            f_tipy_in = TW'($signed(t_crd_ff[IDX_PY]));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= t_valid_ff;
      end
      if (en) begin
         f_from_ff   <= f_from_in;
         f_tipx_ff   <= f_tipx_in;
         f_tipy_ff   <= f_tipy_in;
         f_region_ff <= t_region_ff;
      end
   end

   // ---------------- stage g: result vector, saturated tip ------------
   logic                  g_valid_ff;
   logic [1:0][C-1:0]     g_from_ff, g_tip_ff, g_tip_in;
   logic signed [TW-1:0]  g_rx_ff, g_ry_ff;
   region_type            g_region_ff;

   always_comb begin
      if (f_tipx_ff > TIP_HI) begin
         g_tip_in[0] = TIP_HI[C-1:0];
      end else if (f_tipx_ff < TIP_LO) begin
         g_tip_in[0] = TIP_LO[C-1:0];
      end else begin
         g_tip_in[0] = f_tipx_ff[C-1:0];
      end
      if (f_tipy_ff > TIP_HI) begin
         g_tip_in[1] = TIP_HI[C-1:0];
      end else if (f_tipy_ff < TIP_LO) begin
         g_tip_in[1] = TIP_LO[C-1:0];
      end else begin
         g_tip_in[1] = f_tipy_ff[C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (en) begin
         g_valid_ff <= f_valid_ff;
      end
      if (en) begin
         g_from_ff   <= f_from_ff;
         g_tip_ff    <= g_tip_in;
         g_region_ff <= f_region_ff;
         g_rx_ff     <= f_tipx_ff - TW'($signed(f_from_ff[0]));
         g_ry_ff     <= f_tipy_ff - TW'($signed(f_from_ff[1]));
      end
   end

   // ---------------- stage h: squared components ----------------------
   logic                  h_valid_ff;
   logic [RPW-1:0]        h_pay_ff;
   logic [SQW-1:0]        h_sqx_ff, h_sqy_ff;
   logic signed [2*TW-1:0] h_sqx_in, h_sqy_in;

   assign h_sqx_in = (2*TW)'(g_rx_ff) * (2*TW)'(g_rx_ff);
   assign h_sqy_in = (2*TW)'(g_ry_ff) * (2*TW)'(g_ry_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= g_valid_ff;
      end
      if (en) begin
         h_pay_ff <= {g_region_ff, g_tip_ff, g_from_ff};
         h_sqx_ff <= h_sqx_in[SQW-1:0];
         h_sqy_ff <= h_sqy_in[SQW-1:0];
      end
   end

   // ---------------- stage s: squared length, scaled ------------------
   logic                  s_valid_ff;
   logic [RPW-1:0]        s_pay_ff;
   logic [DSW-1:0]        s_dsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff <= h_valid_ff;
      end
      if (en) begin
         s_pay_ff <= h_pay_ff;
         s_dsq_ff <= DSW'(h_sqx_ff + h_sqy_ff) << (2*DIST_FRAC);
      end
   end

   // ---------------- distance root ------------------------------------
   logic                  ds_valid;
   logic [0:0][DK-1:0]    ds_root;
   logic [RPW-1:0]        ds_pay;
   logic [DCW-1:0]        ds_wide;
   logic [DIST_BITS-1:0]  ds_dist;

   pssv_sqrt_pipe #(
      .W     (DSW),
      .LANES (1),
      .PW    (RPW)
   ) u_dist_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s_valid_ff),
      .in_data     (s_dsq_ff),
      .in_payload  (s_pay_ff),
      .out_valid   (ds_valid),
      .out_root    (ds_root),
      .out_payload (ds_pay)
   );

   assign ds_wide = DCW'(ds_root[0]);
   assign ds_dist = (ds_wide > DIST_MAX) ? DIST_BITS'(DIST_MAX) : DIST_BITS'(ds_wide);

   // ---------------- output queue, two words --------------------------
   logic [FQW-1:0] fifo_mem_ff [2];
   logic           fifo_wr_ff, fifo_rd_ff;
   logic [1:0]     fifo_cnt_ff;
   logic           push, pop;

   assign en         = (fifo_cnt_ff != 2'd2) || rsp_tready;
   assign req_tready = en && !reset;
   assign push       = en && ds_valid;
   assign rsp_tvalid = (fifo_cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[fifo_wr_ff] <= {ds_pay[RPW-1 -: 2], ds_dist, ds_pay[4*C-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ff  <= 1'b0;
         fifo_rd_ff  <= 1'b0;
         fifo_cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            fifo_wr_ff <= !fifo_wr_ff;
         end
         if (pop) begin
            fifo_rd_ff <= !fifo_rd_ff;
         end
         case ({push, pop})
            2'b10:   fifo_cnt_ff <= fifo_cnt_ff + 2'd1;
            2'b01:   fifo_cnt_ff <= fifo_cnt_ff - 2'd1;
            default: fifo_cnt_ff <= fifo_cnt_ff;
         endcase
      end
   end

   assign rsp_tdata = OUT_TW'(fifo_mem_ff[fifo_rd_ff][OUT_FW-1:0]);
   assign rsp_tuser = fifo_mem_ff[fifo_rd_ff][FQW-1 -: 2];

   // ---------------- checks -------------------------------------------
   `PSSV_ASSERT_IMP(a_no_overflow, push && (fifo_cnt_ff == 2'd2), rsp_tready, "queue overflow")
   `PSSV_ASSERT_IMP(a_cnt_range, 1'b1, fifo_cnt_ff != 2'd3, "queue count out of range")
   `PSSV_ASSERT_NXT(a_stall_holds, !en && ds_valid, ds_valid, "stalled result lost")

endmodule

FILE: rtl/core/pssv_div_pipe.sv
// Pipelined restoring divider, two numerators over one shared denominator.
// One quotient bit per stage; the first stage yields the integer bit, every
// later stage one fraction bit. Numerators must not exceed the denominator.
module pssv_div_pipe #(
   parameter int NW = 33,
   parameter int QW = 33,
   parameter int PW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [1:0][NW-1:0]     in_numer,
   input  logic [NW-1:0]          in_denom,
   input  logic [PW-1:0]          in_payload,
   output logic                   out_valid,
   output logic [1:0][QW-1:0]     out_quot,
   output logic [PW-1:0]          out_payload
);

   logic                valid_ff [QW];
   logic [1:0][NW-1:0]  rem_ff   [QW];
   logic [1:0][QW-1:0]  quot_ff  [QW];
   logic [NW-1:0]       denom_ff [QW];
   logic [PW-1:0]       pay_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [1:0][NW-1:0] rem_in;
      logic [1:0][QW-1:0] quot_in;

      if (i == 0) begin : g_first
         // integer bit: numerator against denominator
         always_comb begin
            for (int k = 0; k < 2; k++) begin
               if (in_numer[k] >= in_denom) begin
                  rem_in[k]  = in_numer[k] - in_denom;
                  quot_in[k] = {{(QW-1){1'b0}}, 1'b1};
               end else begin
                  rem_in[k]  = in_numer[k];
                  quot_in[k] = '0;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= in_valid;
            end
            if (en) begin
               rem_ff[i]   <= rem_in;
               quot_ff[i]  <= quot_in;
               denom_ff[i] <= in_denom;
               pay_ff[i]   <= in_payload;
            end
         end
      end else begin : g_step
         // one fraction bit: shift remainder, trial subtract
         always_comb begin
            logic [NW:0] shifted;
            for (int k = 0; k < 2; k++) begin
               shifted = {rem_ff[i-1][k], 1'b0};
               if (shifted >= {1'b0, denom_ff[i-1]}) begin
                  rem_in[k]  = NW'(shifted - {1'b0, denom_ff[i-1]});
                  quot_in[k] = {quot_ff[i-1][k][QW-2:0], 1'b1};
               end else begin
                  rem_in[k]  = shifted[NW-1:0];
                  quot_in[k] = {quot_ff[i-1][k][QW-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= valid_ff[i-1];
            end
            if (en) begin
               rem_ff[i]   <= rem_in;
               quot_ff[i]  <= quot_in;
               denom_ff[i] <= denom_ff[i-1];
               pay_ff[i]   <= pay_ff[i-1];
            end
         end
      end
   end

   assign out_valid   = valid_ff[QW-1];
   assign out_quot    = quot_ff[QW-1];
   assign out_payload = pay_ff[QW-1];

endmodule

FILE: rtl/core/pssv_sqrt_pipe.sv
// Pipelined integer square root, floor(sqrt(x)), one root bit per stage,
// LANES independent operands sharing the stage valid and payload.
module pssv_sqrt_pipe #(
   parameter int W     = 33,
   parameter int LANES = 2,
   parameter int PW    = 8,
   localparam int K    = (W + 1) / 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [LANES-1:0][W-1:0]   in_data,
   input  logic [PW-1:0]             in_payload,
   output logic                      out_valid,
   output logic [LANES-1:0][K-1:0]   out_root,
   output logic [PW-1:0]             out_payload
);

   localparam int RW = 2 * K + 1;

   logic                     valid_ff [K];
   logic [LANES-1:0][RW-1:0] rad_ff   [K];
   logic [LANES-1:0][RW-1:0] res_ff   [K];
   logic [PW-1:0]            pay_ff   [K];

   for (genvar i = 0; i < K; i++) begin : g_stage
      localparam int SH = 2 * (K - 1 - i);
      localparam logic [RW-1:0] BIT_VAL = {{(RW-1){1'b0}}, 1'b1} << SH;

      logic                     prev_valid;
      logic [LANES-1:0][RW-1:0] prev_rad;
      logic [LANES-1:0][RW-1:0] prev_res;
      logic [PW-1:0]            prev_pay;
      logic [LANES-1:0][RW-1:0] rad_in;
      logic [LANES-1:0][RW-1:0] res_in;

      if (i == 0) begin : g_first
         always_comb begin
            prev_valid = in_valid;
            prev_pay   = in_payload;
            for (int k = 0; k < LANES; k++) begin
               prev_rad[k] = RW'(in_data[k]);
               prev_res[k] = '0;
            end
         end
      end else begin : g_next
         assign prev_valid = valid_ff[i-1];
         assign prev_rad   = rad_ff[i-1];
         assign prev_res   = res_ff[i-1];
         assign prev_pay   = pay_ff[i-1];
      end

      // trial subtract of (res + bit)
      always_comb begin
         logic [RW-1:0] trial;
         for (int k = 0; k < LANES; k++) begin
            trial = prev_res[k] + BIT_VAL;
            if (prev_rad[k] >= trial) begin
               rad_in[k] = prev_rad[k] - trial;
               res_in[k] = (prev_res[k] >> 1) + BIT_VAL;
            end else begin
               rad_in[k] = prev_rad[k];
               res_in[k] = prev_res[k] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= prev_valid;
         end
         if (en) begin
            rad_ff[i] <= rad_in;
            res_ff[i] <= res_in;
            pay_ff[i] <= prev_pay;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         out_root[k] = res_ff[K-1][k][K-1:0];
      end
   end

   assign out_valid   = valid_ff[K-1];
   assign out_payload = pay_ff[K-1];

endmodule

FILE: tb/tb_top.sv
module tb_top
   import pssv_pkg::*;
();

   localparam int CB = 16;
   localparam int FB = 16;
   localparam int IN_TW = 96;
   localparam int OUT_TW = 96;
   localparam int PIPE_DEPTH = 3 * FB + CB + 24;

   typedef struct packed {
      logic signed [15:0] ey, ex, sy, sx, py, px;
   } query_type;

   typedef struct {
      logic [15:0] from_x, from_y, to_x, to_y;
      region_type  reg_code;
      logic [24:0] len_q8;
   } vector_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [IN_TW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [OUT_TW-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   point_segment_shortest_vector_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      // point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      // vec_from_x, vec_from_y, vec_to_x, vec_to_y, distance
      .rsp_tdata(rsp_tdata),
      // region
      .rsp_tuser(rsp_tuser)
   );

   query_type  pending_q[$];
   vector_type expected_q[$];
   int         error_count = 0;
   bit         stim_done = 0;
   bit         drain_hold = 0;
   bit         req_acc = 0;
   bit         rsp_acc = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // one direction component normalized to Q2.FB, truncated toward zero
   function automatic longint unit_dir(longint c, longint unsigned len2);
      longint unsigned mag, quo, rem;
      if (len2 == 0) return 0;
      mag = (c < 0) ? -c : c;
      quo = (mag * mag >= len2) ? 1 : 0;
      rem = mag * mag - (quo ? len2 : 0);
      for (int i = 0; i < 2 * FB; i++) begin
         rem <<= 1;
         quo <<= 1;
         if (rem >= len2) begin
            rem -= len2;
            quo |= 1;
         end
      end
      mag = int_sqrt(quo);
      return (c < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint shift_toward_zero(longint v, int sh);
      longint unsigned m;
      m = ((v < 0) ? -v : v) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic vector_type shortest_vector(query_type q);
      vector_type r;
      longint px, py, sx, sy, ex, ey, vx, vy, ux, uy, wx, wy;
      longint fx, fy, tx, ty, rx, ry, d;
      longint unsigned len2, sq, len_q8;
      px = q.px; py = q.py; sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey;
      vx = ex - sx;
      vy = ey - sy;
      len2 = vx * vx + vy * vy;
      ux = unit_dir(vx, len2);
      uy = unit_dir(vy, len2);
      wx = px - sx;
      wy = py - sy;
      if (wx * ux + wy * uy < 0) begin
         r.reg_code = REGION_BEFORE;
         fx = sx; fy = sy; tx = px; ty = py;
      end else if ((px - ex) * ux + (py - ey) * uy > 0) begin
         r.reg_code = REGION_AFTER;
         fx = ex; fy = ey; tx = px; ty = py;
      end else begin
         // tip is the segment start plus the point's offset normal to the segment
         d = wx * uy - wy * ux;
         r.reg_code = REGION_INTERIOR;
         fx = sx; fy = sy;
         tx = shift_toward_zero((sx <<< (2 * FB)) + d * uy, 2 * FB);
         ty = shift_toward_zero((sy <<< (2 * FB)) - d * ux, 2 * FB);
      end
      rx = tx - fx;
      ry = ty - fy;
      sq = rx * rx + ry * ry;
      len_q8 = int_sqrt(sq << (2 * DIST_FRAC));
      if (len_q8 > 25'h1FFFFFF) len_q8 = 25'h1FFFFFF;
      r.from_x = fx[15:0];
      r.from_y = fy[15:0];
      r.to_x = 16'(clamp_coord(tx));
      r.to_y = 16'(clamp_coord(ty));
      r.len_q8 = len_q8[24:0];
      return r;
   endfunction

   function automatic query_type make_query(int px, int py, int sx, int sy, int ex, int ey);
      query_type q;
      q.px = 16'(px); q.py = 16'(py); q.sx = 16'(sx);
      q.sy = 16'(sy); q.ex = 16'(ex); q.ey = 16'(ey);
      return q;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      query_type q;
      int c;
      pending_q.push_back(make_query(0, 0, 0, 0, 0, 0));
      pending_q.push_back(make_query(5, -7, 3, 3, 3, 3));
      pending_q.push_back(make_query(-5, 1, 0, 0, 10, 0));
      pending_q.push_back(make_query(15, 1, 0, 0, 10, 0));
      pending_q.push_back(make_query(4, 6, 0, 0, 10, 0));
      pending_q.push_back(make_query(4, -6, 0, 0, 10, 0));
      pending_q.push_back(make_query(3, 7, -2, 1, 9, 5));
      pending_q.push_back(make_query(32767, 32767, -32768, -32768, 32767, -32768));
      pending_q.push_back(make_query(-32768, 32767, 32767, -32768, -32768, -32768));
      pending_q.push_back(make_query(32767, -32768, -32768, 32767, 32767, 32767));
      pending_q.push_back(make_query(-32768, -32768, 32767, 32767, -32768, 32767));
      pending_q.push_back(make_query(0, 32767, -32768, 0, 32767, 0));
      pending_q.push_back(make_query(0, -32768, -32768, 0, 32767, 0));
      pending_q.push_back(make_query(32767, 0, 0, -32768, 0, 32767));
      pending_q.push_back(make_query(-32768, 0, 0, 32767, 0, -32768));
      pending_q.push_back(make_query(-32768, -32768, 32767, 32767, 32767, 32767));
      pending_q.push_back(make_query(100, 100, 0, 0, 200, 200));
      pending_q.push_back(make_query(-1, -1, 0, 0, 1, 1));
      pending_q.push_back(make_query(32767, -32768, -32768, -32768, -32768, 32767));
      for (int i = 0; i < 500; i++) begin
         q = make_query(int'($signed(rand_coord())), int'($signed(rand_coord())),
            int'($signed(rand_coord())), int'($signed(rand_coord())),
            int'($signed(rand_coord())), int'($signed(rand_coord())));
         c = $urandom_range(0, 3);
         // some degenerate and short segments
         if (c == 0) begin
            q.ex = q.sx;
            q.ey = q.sy;
         end else if (c == 1) begin
            q.ex = q.sx + $signed(4'($urandom));
            q.ey = q.sy + $signed(4'($urandom));
         end
         pending_q.push_back(q);
      end
      repeat (7) @(posedge clock);
      reset <= 0;
   end

   // handshakes seen at the rising edge
   always @(posedge clock) begin
      req_acc = !reset && req_tvalid && req_tready;
      rsp_acc = !reset && rsp_tvalid && rsp_tready;
   end

   // request driver
   int send_gap = 0;
   int sent = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_acc) begin
            expected_q.push_back(shortest_vector(query_type'(req_tdata)));
            pending_q.pop_front();
            sent++;
            send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if ((sent / 100) % 2 == 1) send_gap = 0;
            if (sent == 250) drain_hold = 1;
         end
         if (drain_hold && expected_q.size() == 0) drain_hold = 0;
         if (pending_q.size() == 0) begin
            req_tvalid <= 0;
            stim_done = 1;
         end else if (drain_hold) begin
            req_tvalid <= 0;
         end else if (send_gap > 0 && !(req_tvalid && !req_acc)) begin
            send_gap--;
            req_tvalid <= 0;
         end else begin
            req_tvalid <= 1;
            req_tdata <= pending_q[0];
         end
      end
   end

   // response ready
   int recv_gap = 0;
   int received = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_acc) begin
            received++;
            recv_gap = ((received / 120) % 2 == 1) ? 0 : $urandom_range(0, 18);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      vector_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word tdata=%h tuser=%0d", $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata[15:0] !== e.from_x || rsp_tdata[31:16] !== e.from_y ||
                rsp_tdata[47:32] !== e.to_x || rsp_tdata[63:48] !== e.to_y ||
                rsp_tdata[88:64] !== e.len_q8 || rsp_tuser !== e.reg_code) begin
               $display("%0t: expected from=(%0d,%0d) to=(%0d,%0d) length=%0d region=%0d",
                  $time, $signed(e.from_x), $signed(e.from_y), $signed(e.to_x),
                  $signed(e.to_y), e.len_q8, e.reg_code);
               $display("%0t: actual   from=(%0d,%0d) to=(%0d,%0d) length=%0d region=%0d",
                  $time, $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]),
                  $signed(rsp_tdata[47:32]), $signed(rsp_tdata[63:48]),
                  rsp_tdata[88:64], rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done && expected_q.size() == 0);
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0)
         $display("point_segment_shortest_vector_top verification clean");
      else
         $display("point_segment_shortest_vector_top verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("point_segment_shortest_vector_top verification failed");
      $finish;
   end

endmodule
